### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is low
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bump gradient check failed");

// Check that a condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_AT(label, clk, rst_n, !(cond))

`endif

### design/bgd_pkg.sv
// Package with constants and types for the bump gradient displacement block
package bgd_pkg;

  localparam int unsigned SIDE      = 256;
  localparam int unsigned STEP      = 2;
  localparam int unsigned OUT_SHIFT = 8;

  localparam int unsigned DELAY       = STEP * SIDE + STEP;
  localparam int unsigned FRAME_ITEMS = SIDE * SIDE + DELAY;
  localparam int unsigned POS_W       = $clog2(FRAME_ITEMS);
  localparam int unsigned COORD_W     = $clog2(SIDE);

  localparam int unsigned LINE1_DEPTH = STEP * SIDE;
  localparam int unsigned LINE1_AW    = $clog2(LINE1_DEPTH);
  localparam int unsigned LINE2_DEPTH = STEP * SIDE + STEP - 1;
  localparam int unsigned LINE2_AW    = $clog2(LINE2_DEPTH);

  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DISP_W   = 32;
  localparam int unsigned DIFF_W   = HEIGHT_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + GAIN_W;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned QUOT_W   = PROD_W - FRAC_W;
  localparam int unsigned FRAC_MASK = (1 << FRAC_W) - 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd256;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     last;
  } bgd_job_t;

  typedef struct packed {
    logic [DISP_W-1:0] x_disp;
    logic [DISP_W-1:0] y_disp;
    logic              frame_end;
  } bgd_result_t;

endpackage

### design/bgd_front.sv
// Front end: beat intake, line buffers, position tracking and neighbor differences
module bgd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         opcode_i,
  input  logic [bgd_pkg::HEIGHT_W-1:0] height_i,
  input  logic [bgd_pkg::QUEUE_CW-1:0] q_count_i,
  output logic                         full_o,
  output logic                         job_valid_o,
  output bgd_pkg::bgd_job_t            job_o
);
  import bgd_pkg::*;

  logic [HEIGHT_W-1:0] line1_mem [LINE1_DEPTH];
  logic [HEIGHT_W-1:0] line2_mem [LINE2_DEPTH];
  logic [HEIGHT_W-1:0] rd1_q, rd2_q;
  logic [HEIGHT_W-1:0] lower_q [STEP+1];
  logic [HEIGHT_W-1:0] left_q  [2*STEP];

  logic [LINE1_AW-1:0] wp1_q, wp1_d;
  logic [LINE2_AW-1:0] wp2_q, wp2_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [COORD_W-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic                job_valid_q, xok_q, yok_q, last_q;

  logic                accept, emit, xok, yok, last;
  logic [HEIGHT_W-1:0] h;
  logic [QUEUE_CW:0]   used;

  assign used   = {1'b0, q_count_i} + {{QUEUE_CW{1'b0}}, job_valid_q};
  assign full_o = used >= (QUEUE_CW+1)'(QUEUE_DEPTH);
  assign accept = push_i && !full_o;
  assign h      = (opcode_i == OP_FLUSH) ? '0 : height_i;
  assign emit   = accept && (pos_q >= POS_W'(DELAY));

  assign xok  = (qx_q >= COORD_W'(STEP)) && (qx_q <= COORD_W'(SIDE - 1 - STEP));
  assign yok  = (qy_q >= COORD_W'(STEP)) && (qy_q <= COORD_W'(SIDE - 1 - STEP));
  assign last = (qx_q == COORD_W'(SIDE - 1)) && (qy_q == COORD_W'(SIDE - 1));

  always_comb begin
    wp1_d = wp1_q;
    wp2_d = wp2_q;
    pos_d = pos_q;
    qx_d  = qx_q;
    qy_d  = qy_q;
    if (accept) begin
      wp1_d = (wp1_q == LINE1_AW'(LINE1_DEPTH - 1)) ? '0 : wp1_q + 1'b1;
      wp2_d = (wp2_q == LINE2_AW'(LINE2_DEPTH - 1)) ? '0 : wp2_q + 1'b1;
      pos_d = (pos_q == POS_W'(FRAME_ITEMS - 1)) ? '0 : pos_q + 1'b1;
    end
    if (emit) begin
      if (qx_q == COORD_W'(SIDE - 1)) begin
        qx_d = '0;
        qy_d = last ? '0 : qy_q + 1'b1;
      end else begin
        qx_d = qx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp1_q       <= '0;
      wp2_q       <= '0;
      pos_q       <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      job_valid_q <= 1'b0;
      xok_q       <= 1'b0;
      yok_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      wp1_q       <= wp1_d;
      wp2_q       <= wp2_d;
      pos_q       <= pos_d;
      qx_q        <= qx_d;
      qy_q        <= qy_d;
      job_valid_q <= emit;
      xok_q       <= xok;
      yok_q       <= yok;
      last_q      <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line1_mem[wp1_q] <= h;
      rd1_q            <= line1_mem[wp1_q];
      line2_mem[wp2_q] <= rd1_q;
      rd2_q            <= line2_mem[wp2_q];
      lower_q[0]       <= h;
      for (int i = 1; i <= STEP; i++) begin
        lower_q[i] <= lower_q[i-1];
      end
      left_q[0] <= rd1_q;
      for (int i = 1; i < 2*STEP; i++) begin
        left_q[i] <= left_q[i-1];
      end
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o.dx    = xok_q ? $signed({1'b0, left_q[2*STEP-1]}) - $signed({1'b0, rd1_q})
                             : '0;
  assign job_o.dy    = yok_q ? $signed({1'b0, rd2_q}) - $signed({1'b0, lower_q[STEP]})
                             : '0;
  assign job_o.last  = last_q;

endmodule

### design/bgd_queue.sv
// Short queue of difference jobs between the front and back ends
module bgd_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bgd_pkg::bgd_job_t            job_i,
  input  logic                         pop_i,
  output bgd_pkg::bgd_job_t            job_o,
  output logic                         empty_o,
  output logic [bgd_pkg::QUEUE_CW-1:0] count_o
);
  import bgd_pkg::*;

  bgd_job_t            slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, rp_q;
  logic [QUEUE_CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + QUEUE_CW'(push_i) - QUEUE_CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rp_q];
  assign empty_o = cnt_q == '0;
  assign count_o = cnt_q;

endmodule

### design/bgd_back.sv
// Back end: gain multiply, truncating rescale, shift and result queue
module bgd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [bgd_pkg::GAIN_W-1:0] gain_i,
  input  logic                              job_valid_i,
  input  bgd_pkg::bgd_job_t                 job_i,
  output logic                              job_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output bgd_pkg::bgd_result_t              result_o
);
  import bgd_pkg::*;

  function automatic logic [DISP_W-1:0] scale(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] biased;
    logic signed [QUOT_W-1:0] quo;
    logic signed [DISP_W-1:0] wide;
    biased = prod[PROD_W-1] ? prod + $signed(PROD_W'(FRAC_MASK)) : prod;
    quo    = QUOT_W'(biased >>> FRAC_W);
    wide   = DISP_W'(quo);
    return wide << OUT_SHIFT;
  endfunction

  logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
  logic                     s1_last_q, s1_valid_q;
  bgd_result_t              res_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]      wp_q, rp_q;
  logic [QUEUE_CW-1:0]      cnt_q;
  logic [QUEUE_CW:0]        used;
  logic                     take, out_pop;
  bgd_result_t              res_in;

  assign used      = {1'b0, cnt_q} + {{QUEUE_CW{1'b0}}, s1_valid_q};
  assign take      = job_valid_i && (used < (QUEUE_CW+1)'(QUEUE_DEPTH));
  assign job_pop_o = take;
  assign empty_o   = cnt_q == '0;
  assign out_pop   = pop_i && !empty_o;

  assign res_in.x_disp    = scale(prod_x_q);
  assign res_in.y_disp    = scale(prod_y_q);
  assign res_in.frame_end = s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wp_q       <= '0;
      rp_q       <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= take;
      if (s1_valid_q) begin
        wp_q <= wp_q + 1'b1;
      end
      if (out_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + QUEUE_CW'(s1_valid_q) - QUEUE_CW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_x_q  <= job_i.dx * gain_i;
      prod_y_q  <= job_i.dy * gain_i;
      s1_last_q <= job_i.last;
    end
    if (s1_valid_q) begin
      res_q[wp_q] <= res_in;
    end
  end

  assign result_o = res_q[rp_q];

endmodule

### design/bump_gradient_displacement.sv
// Top level of the bump gradient displacement block
// Takes a 256 x 256 bump map as a raster stream of 8-bit heights, one beat per clock
// while full is low, and returns for every pixel a horizontal and a vertical displacement:
// the height two places before minus the height two places after, times the signed
// Q8.8 gain, truncated toward zero, shifted left by 8 and given as 32 bits. Edge
// pixels whose neighbor lies outside the image get zero. The result for a pixel
// leaves once the beat two rows plus two pixels later has been pushed, so each frame
// is followed by 514 flush beats (or any further beats) that drain the last results;
// after the result marked frame_end the next beat starts a new frame. The rate of
// one beat per clock is set by the two line-buffer RAMs (512 and 513 entries), each
// doing one write and one registered read per beat. Once the beat completing a window
// is accepted, its result passes the front-end job register, a four-entry queue between
// the front end and the multiplier stage, the product register and a four-entry result
// queue to the result ports. No clearing pass after reset.
module bump_gradient_displacement (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode_i,
  input  logic [bgd_pkg::HEIGHT_W-1:0]      height_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [bgd_pkg::DISP_W-1:0] x_disp_o,
  output logic signed [bgd_pkg::DISP_W-1:0] y_disp_o,
  output logic                              frame_end_o,
  input  logic                              gain_we_i,
  input  logic signed [bgd_pkg::GAIN_W-1:0] gain_i
);
  import bgd_pkg::*;

  logic signed [GAIN_W-1:0] gain_q;
  logic                     job_valid, q_empty, q_pop;
  logic [QUEUE_CW-1:0]      q_count;
  bgd_job_t                 job_in, job_out;
  bgd_result_t              result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (gain_we_i) begin
      gain_q <= gain_i;
    end
  end

  bgd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .opcode_i    (opcode_i),
    .height_i    (height_i),
    .q_count_i   (q_count),
    .full_o      (full),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  bgd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job_in),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  bgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign x_disp_o    = $signed(result.x_disp);
  assign y_disp_o    = $signed(result.y_disp);
  assign frame_end_o = result.frame_end;

endmodule

### design/bgd_checker.sv
// Port-level checker for the bump gradient displacement block, with its bind
`include "assert_macros.svh"

module bgd_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] x_disp_o,
  input logic [31:0] y_disp_o,
  input logic        frame_end_o
);

  logic [64:0] beat;
  logic        disp_nz;

  assign beat    = {x_disp_o, y_disp_o, frame_end_o};
  assign disp_nz = (x_disp_o != '0) || (y_disp_o != '0);

  `ASSERT_AT(a_result_holds, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(beat))
  `ASSERT_NEVER(a_corner_is_edge, clk_i, rst_ni, !empty && frame_end_o && disp_nz)
  `ASSERT_AT(a_frame_restart, clk_i, rst_ni, !empty && pop && frame_end_o |=> empty || (!frame_end_o && !disp_nz))

endmodule

bind bump_gradient_displacement bgd_port_checker u_bgd_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .x_disp_o    (x_disp_o),
  .y_disp_o    (y_disp_o),
  .frame_end_o (frame_end_o)
);
